>>> hdl/lookup_linear_interp_q10_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lookup and linear interpolation unit
// Shared property forms used by the modules that carry assertions.
// ----------------------------------------------------------------------------
`ifndef LOOKUP_LINEAR_INTERP_Q10_UNIT_ASSERT_SVH
`define LOOKUP_LINEAR_INTERP_Q10_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/lli_pkg.sv
// ----------------------------------------------------------------------------
// Lookup and linear interpolation package
// Item kinds, fixed-point constants and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lli_pkg;

  localparam int VAL_W     = 16;
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 4;
  localparam int FRAC_BITS = 10;
  localparam int NUM_W     = VAL_W + FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int PROD_W    = (VAL_W + 1) + (FRAC_W + 1);

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_BP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WR_OUT = 2'd2;

  localparam logic [IDX_W-1:0] LAST_INDEX_RESET = 4'd15;

  typedef struct packed {
    logic x_load;
    logic bp_we;
    logic out_we;
    logic bp_re;
    logic out_re;
    logic lo_load;
    logic hi_load;
    logic div_start;
    logic div_step;
    logic olo_load;
    logic ohi_load;
    logic mul_load;
    logic res_load;
    logic res_sel;
  } lli_cmd_t;

  typedef struct packed {
    logic x_lt_bp;
  } lli_stat_t;

endpackage

>>> hdl/lli_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module lli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/lli_datapath.sv
// ----------------------------------------------------------------------------
// Lookup and linear interpolation datapath
// Table memories, segment registers, serial divider, multiplier and result.
// ----------------------------------------------------------------------------
module lli_datapath
  import lli_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic [VAL_W-1:0]               in_value,
  input  lli_cmd_t                       cmd,
  input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
  input  logic [$clog2(TABLE_DEPTH)-1:0] bp_raddr,
  input  logic [$clog2(TABLE_DEPTH)-1:0] out_raddr,
  output lli_stat_t                      stat,
  output logic [VAL_W-1:0]               result
);

  logic [VAL_W-1:0]         bp_rdata;
  logic [VAL_W-1:0]         out_rdata;
  logic signed [VAL_W-1:0]  x_r;
  logic [VAL_W-1:0]         bp_lo_r;
  logic [VAL_W-1:0]         bp_hi_r;
  logic [VAL_W-1:0]         den_r;
  logic [VAL_W-1:0]         rem_r;
  logic [NUM_W-1:0]         num_r;
  logic                     dz_r;
  logic [VAL_W-1:0]         out_lo_r;
  logic [VAL_W-1:0]         out_hi_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [VAL_W-1:0]         res_r;

  logic [VAL_W-1:0]         den_nxt;
  logic [VAL_W-1:0]         span_nxt;
  logic [VAL_W:0]           rem_shift;
  logic                     rem_ge;
  logic [FRAC_W-1:0]        frac;
  logic signed [VAL_W:0]    diff;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [VAL_W-1:0]         sum;

  lli_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_bp_ram (
    .clk   (clk),
    .we    (cmd.bp_we),
    .waddr (waddr),
    .wdata (in_value),
    .re    (cmd.bp_re),
    .raddr (bp_raddr),
    .rdata (bp_rdata)
  );

  lli_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_out_ram (
    .clk   (clk),
    .we    (cmd.out_we),
    .waddr (waddr),
    .wdata (in_value),
    .re    (cmd.out_re),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  assign stat.x_lt_bp = x_r < $signed(bp_rdata);

  assign den_nxt   = bp_hi_r - bp_lo_r;
  assign span_nxt  = x_r - bp_lo_r;
  assign rem_shift = {rem_r, num_r[NUM_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, den_r};

  assign frac     = dz_r ? '0 : num_r[FRAC_W-1:0];
  assign diff     = $signed({out_hi_r[VAL_W-1], out_hi_r})
                    - $signed({out_lo_r[VAL_W-1], out_lo_r});
  assign prod_nxt = diff * $signed({1'b0, frac});
  assign sum      = out_lo_r + prod_r[FRAC_BITS +: VAL_W];

  always_ff @(posedge clk) begin
    if (cmd.x_load) begin
      x_r <= in_value;
    end
    if (cmd.lo_load) begin
      bp_lo_r <= bp_rdata;
    end
    if (cmd.hi_load) begin
      bp_hi_r <= bp_rdata;
    end
    if (cmd.div_start) begin
      num_r <= {span_nxt, {FRAC_BITS{1'b0}}};
      den_r <= den_nxt;
      dz_r  <= den_nxt == '0;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? VAL_W'(rem_shift - {1'b0, den_r}) : rem_shift[VAL_W-1:0];
      num_r <= {num_r[NUM_W-2:0], rem_ge};
    end
    if (cmd.olo_load) begin
      out_lo_r <= out_rdata;
    end
    if (cmd.ohi_load) begin
      out_hi_r <= out_rdata;
    end
    if (cmd.mul_load) begin
      prod_r <= prod_nxt;
    end
    if (cmd.res_load) begin
      res_r <= cmd.res_sel ? sum : out_rdata;
    end
  end

  assign result = res_r;

endmodule

>>> hdl/lli_ctrl.sv
// ----------------------------------------------------------------------------
// Lookup and linear interpolation controller
// Holds the last-index register, walks the breakpoints and sequences the
// divider, multiplier and output register.
// ----------------------------------------------------------------------------
module lli_ctrl
  import lli_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [KIND_W-1:0]              in_kind,
  input  logic [IDX_W-1:0]               in_idx,
  input  logic                           cfg_we,
  input  logic [IDX_W-1:0]               cfg_wdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  lli_stat_t                      stat,
  output lli_cmd_t                       cmd,
  output logic [$clog2(TABLE_DEPTH)-1:0] waddr,
  output logic [$clog2(TABLE_DEPTH)-1:0] bp_raddr,
  output logic [$clog2(TABLE_DEPTH)-1:0] out_raddr
);

  `include "lookup_linear_interp_q10_unit_assert.svh"

  localparam int IW = $clog2(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK0    = 4'd1;
  localparam logic [3:0] S_DOWN    = 4'd2;
  localparam logic [3:0] S_UP      = 4'd3;
  localparam logic [3:0] S_DIVINIT = 4'd4;
  localparam logic [3:0] S_DIV     = 4'd5;
  localparam logic [3:0] S_MUL     = 4'd6;
  localparam logic [3:0] S_RES     = 4'd7;
  localparam logic [3:0] S_SINGLE  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [IW-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] last_index_r;
  logic             out_valid_r, out_valid_nxt;
  logic [IW-1:0]    last_eff;
  logic             idx_ok;
  logic             accept;
  logic             out_free;

  assign last_eff = (32'(last_index_r) > TABLE_DEPTH - 1) ? IW'(TABLE_DEPTH - 1)
                                                          : IW'(last_index_r);
  assign idx_ok   = 32'(in_idx) < TABLE_DEPTH;
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign waddr    = IW'(in_idx);

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    bp_raddr  = '0;
    out_raddr = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_kind)
            KIND_LOOKUP: begin
              cmd.x_load  = 1'b1;
              cmd.bp_re   = 1'b1;
              state_nxt   = S_CHK0;
            end
            KIND_WR_BP: begin
              cmd.bp_we = idx_ok;
            end
            KIND_WR_OUT: begin
              cmd.out_we = idx_ok;
            end
            default: begin
            end
          endcase
        end
      end
      S_CHK0: begin
        if (stat.x_lt_bp) begin
          cmd.out_re = 1'b1;
          state_nxt  = S_SINGLE;
        end else begin
          i_nxt     = last_eff >> 1;
          cmd.bp_re = 1'b1;
          bp_raddr  = last_eff >> 1;
          state_nxt = S_DOWN;
        end
      end
      S_DOWN: begin
        if (i_r != '0 && stat.x_lt_bp) begin
          i_nxt     = IW'(i_r - 1'b1);
          cmd.bp_re = 1'b1;
          bp_raddr  = IW'(i_r - 1'b1);
        end else begin
          cmd.lo_load = 1'b1;
          if (i_r == last_eff) begin
            cmd.out_re = 1'b1;
            out_raddr  = i_r;
            state_nxt  = S_SINGLE;
          end else begin
            cmd.bp_re = 1'b1;
            bp_raddr  = IW'(i_r + 1'b1);
            state_nxt = S_UP;
          end
        end
      end
      S_UP: begin
        if (!stat.x_lt_bp) begin
          cmd.lo_load = 1'b1;
          i_nxt       = IW'(i_r + 1'b1);
          if (IW'(i_r + 1'b1) == last_eff) begin
            cmd.out_re = 1'b1;
            out_raddr  = IW'(i_r + 1'b1);
            state_nxt  = S_SINGLE;
          end else begin
            cmd.bp_re = 1'b1;
            bp_raddr  = IW'(i_r + 2'd2);
          end
        end else begin
          cmd.hi_load = 1'b1;
          state_nxt   = S_DIVINIT;
        end
      end
      S_DIVINIT: begin
        cmd.div_start = 1'b1;
        cmd.out_re    = 1'b1;
        out_raddr     = i_r;
        cnt_nxt       = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          cmd.olo_load = 1'b1;
          cmd.out_re   = 1'b1;
          out_raddr    = IW'(i_r + 1'b1);
        end
        if (cnt_r == CNT_W'(1)) begin
          cmd.ohi_load = 1'b1;
        end
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = CNT_W'(cnt_r + 1'b1);
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      last_index_r <= LAST_INDEX_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        last_index_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    cnt_r <= cnt_nxt;
  end

  `LLI_ASSERT_IMPL(a_res_slot_free, clk, rst_n, cmd.res_load, !out_valid_r || out_tready)
  `LLI_ASSERT_IMPL(a_up_below_last, clk, rst_n, state_r == S_UP, i_r < last_eff)
  `LLI_ASSERT_NEXT(a_lookup_starts, clk, rst_n, accept && in_kind == KIND_LOOKUP, state_r == S_CHK0)
  `LLI_ASSERT_NEXT(a_div_to_mul, clk, rst_n, state_r == S_DIV && cnt_r == CNT_W'(DIV_STEPS - 1), state_r == S_MUL)

endmodule

>>> hdl/lookup_linear_interp_q10_unit.sv
// ----------------------------------------------------------------------------
// Lookup and linear interpolation unit, Q10 fraction
// One-dimensional breakpoint table lookup with linear interpolation.
//
// Channel  Dir  Handshake            Payload
// in       in   in_tvalid/in_tready  tuser: kind; tdata: entry_index, value
// out      out  out_tvalid/out_tready tdata: result
// cfg      in   cfg_we               cfg_wdata: last_index
//
// A write item is handled in the idle state; a lookup below the first breakpoint
// needs no walk. Otherwise the walk compares one breakpoint per cycle: a lookup that
// ends at the last entry then goes to the output register, any other runs the serial
// divider, one quotient bit per cycle, and the multiplier before the output register.
// Reset is synchronous and active low; the table contents are not cleared.
// A result waits in the output register while the next item is taken; a lookup
// that finishes before that result leaves stalls until it does.
// ----------------------------------------------------------------------------
module lookup_linear_interp_q10_unit
  import lli_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] entry_index, [19:4] value, [23:20] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] result
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  localparam int IW = $clog2(TABLE_DEPTH);

  lli_cmd_t      cmd;
  lli_stat_t     stat;
  logic [IW-1:0] waddr;
  logic [IW-1:0] bp_raddr;
  logic [IW-1:0] out_raddr;

  lli_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .in_idx     (in_tdata[IDX_W-1:0]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .waddr      (waddr),
    .bp_raddr   (bp_raddr),
    .out_raddr  (out_raddr)
  );

  lli_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
    .clk       (clk),
    .in_value  (in_tdata[IDX_W +: VAL_W]),
    .cmd       (cmd),
    .waddr     (waddr),
    .bp_raddr  (bp_raddr),
    .out_raddr (out_raddr),
    .stat      (stat),
    .result    (out_tdata)
  );

endmodule
